// ===== hdl/ucs_pkg.sv =====
// ----------------------------------------------------------------------------
// ucs_pkg
// Types and constants shared by the URL component splitter modules.
// ----------------------------------------------------------------------------
package ucs_pkg;

  localparam int unsigned PosW     = 13;
  localparam int unsigned PortW    = 16;
  localparam int unsigned NumComp  = 9;
  localparam int unsigned CompW    = 4;
  localparam int unsigned SnapDepth = 2;

  typedef enum logic [CompW-1:0] {
    C_SCHEME = 4'd0,
    C_AUTH   = 4'd1,
    C_USER   = 4'd2,
    C_PASS   = 4'd3,
    C_HOST   = 4'd4,
    C_PATH   = 4'd5,
    C_NAME   = 4'd6,
    C_QUERY  = 4'd7,
    C_FRAG   = 4'd8
  } comp_e;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] CaseOfs = 8'h20;

  // Lowercase "https", first character in the low byte.
  localparam logic [39:0] HttpsWord = 40'h73_70_74_74_68;

  localparam logic [PortW-1:0] PortHttps = 16'd443;
  localparam logic [PortW-1:0] PortHttp  = 16'd80;
  localparam logic [PortW-1:0] PortMax   = 16'hFFFF;

  typedef struct packed {
    logic [7:0] url_byte;
    logic       end_of_url;
  } ucs_in_t;

  typedef struct packed {
    logic [CompW-1:0] component;
    logic             present;
    logic [PosW-1:0]  start_res;
    logic [PosW-1:0]  length;
    logic [PortW-1:0] port;
    logic             too_long;
    logic             last_record;
  } ucs_out_t;

  // Finished result of one URL, handed from the scanner to the emitter.
  typedef struct packed {
    logic [NumComp-1:0]           pres;
    logic [NumComp-1:0][PosW-1:0] start;
    logic [NumComp-1:0][PosW-1:0] len;
    logic [PortW-1:0]             port;
    logic                         ovf;
  } ucs_snap_t;

endpackage

// ===== hdl/ucs_stream_if.sv =====
// ----------------------------------------------------------------------------
// ucs_stream_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface ucs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/ucs_scan.sv =====
// ----------------------------------------------------------------------------
// ucs_scan
// Front end: parses one URL byte per cycle while accept_i is high and, on the
// terminator, pushes a snapshot of all component offsets and the port to the queue.
// ----------------------------------------------------------------------------
module ucs_scan import ucs_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  ucs_in_t   req_i,
  output logic      snap_push_o,
  output ucs_snap_t snap_o
);

  localparam logic [PosW-1:0] PosCap = PosW'((MAX_LENGTH > 8191) ? 8191 : MAX_LENGTH);

  typedef enum logic [2:0] {
    PhScheme = 3'd0,
    PhAfter  = 3'd1,
    PhSlash  = 3'd2,
    PhAuth   = 3'd3,
    PhPath   = 3'd4,
    PhQuery  = 3'd5,
    PhFrag   = 3'd6,
    PhUnused = 3'd7
  } phase_e;

  function automatic logic [PosW-1:0] sat_inc(input logic [PosW-1:0] p);
    return (p >= PosCap) ? PosCap : p + PosW'(1);
  endfunction

  function automatic logic [PosW-1:0] span(input logic [PosW-1:0] s, input logic [PosW-1:0] e);
    return (e > s) ? e - s : '0;
  endfunction

  phase_e                       phase_q, phase_d;
  logic [PosW-1:0]              pos_q, pos_d;
  logic [39:0]                  prefix_q, prefix_d;
  logic [NumComp-1:0][PosW-1:0] start_q, start_d;
  logic [NumComp-1:0][PosW-1:0] len_q, len_d;
  logic [NumComp-1:0]           pres_q, pres_d;
  logic [PosW-1:0]              colon_pos_q, colon_pos_d;
  logic                         colon_seen_q, colon_seen_d;
  logic [PortW-1:0]             acc_q, acc_d;
  logic                         digits_q, digits_d;
  logic                         ovf_q, ovf_d;

  logic [PosW-1:0] pos;
  logic [PosW-1:0] auth_start;
  logic [PosW-1:0] pass_start;
  logic [7:0]      c;
  logic [7:0]      lc;
  logic [19:0]     port_v;
  logic            run_end_auth;
  logic            run_path;
  logic            run_end_path;
  logic            match5;
  logic            match4;

  assign c  = req_i.url_byte;
  assign lc = (c >= ChUpA && c <= ChUpZ) ? c + CaseOfs : c;

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    prefix_d     = prefix_q;
    start_d      = start_q;
    len_d        = len_q;
    pres_d       = pres_q;
    colon_pos_d  = colon_pos_q;
    colon_seen_d = colon_seen_q;
    acc_d        = acc_q;
    digits_d     = digits_q;
    ovf_d        = ovf_q;
    pos          = pos_q;
    auth_start   = start_q[C_AUTH];
    pass_start   = '0;
    port_v       = '0;
    run_end_auth = 1'b0;
    run_path     = 1'b0;
    run_end_path = 1'b0;
    match5       = 1'b0;
    match4       = 1'b0;
    snap_push_o  = 1'b0;
    snap_o       = '0;

    if (accept_i && !req_i.end_of_url) begin
      if (pos_q >= PosCap) begin
        pos   = PosCap;
        ovf_d = 1'b1;
      end
      case (phase_q)
        PhScheme: begin
          if (pos < PosW'(5)) begin
            prefix_d[{pos[2:0], 3'b000} +: 8] = lc;
          end
          if (c == ChColon) begin
            pres_d[C_SCHEME]  = 1'b1;
            start_d[C_SCHEME] = '0;
            len_d[C_SCHEME]   = pos;
            start_d[C_PATH]   = sat_inc(pos);
            phase_d           = PhAfter;
          end else if (c == ChSlash) begin
            phase_d = PhSlash;
          end else begin
            run_path = 1'b1;
          end
        end
        PhAfter: begin
          if (c == ChSlash) begin
            phase_d = PhSlash;
          end else begin
            phase_d  = PhPath;
            run_path = 1'b1;
          end
        end
        PhSlash: begin
          if (c == ChSlash) begin
            pres_d[C_AUTH]  = 1'b1;
            start_d[C_AUTH] = sat_inc(pos);
            len_d[C_AUTH]   = '0;
            start_d[C_HOST] = sat_inc(pos);
            start_d[C_USER] = sat_inc(pos);
            colon_seen_d    = 1'b0;
            digits_d        = 1'b0;
            acc_d           = '0;
            phase_d         = PhAuth;
          end else begin
            pres_d[C_NAME]  = 1'b1;
            start_d[C_NAME] = pos;
            len_d[C_NAME]   = '0;
            phase_d         = PhPath;
            run_path        = 1'b1;
          end
        end
        PhAuth: begin
          if (c == ChSlash) begin
            run_end_auth = 1'b1;
            run_path     = 1'b1;
          end else begin
            pres_d[C_HOST] = 1'b1;
            if (c == ChColon) begin
              colon_pos_d  = pos;
              colon_seen_d = 1'b1;
              acc_d        = '0;
              digits_d     = 1'b1;
            end else if (c == ChAt) begin
              pres_d[C_USER]  = 1'b1;
              start_d[C_USER] = auth_start;
              if (colon_seen_q) begin
                pass_start      = sat_inc(colon_pos_q);
                len_d[C_USER]   = span(auth_start, colon_pos_q);
                pres_d[C_PASS]  = 1'b1;
                start_d[C_PASS] = pass_start;
                len_d[C_PASS]   = span(pass_start, pos);
                colon_seen_d    = 1'b0;
              end else begin
                len_d[C_USER] = span(auth_start, pos);
              end
              start_d[C_HOST] = sat_inc(pos);
              digits_d        = 1'b0;
            end else if (c >= ChZero && c <= ChNine && digits_q) begin
              port_v = {4'b0000, acc_q} * 20'd10 + 20'(c - ChZero);
              acc_d  = (port_v > 20'(PortMax)) ? PortMax : port_v[PortW-1:0];
            end else begin
              digits_d = 1'b0;
            end
          end
        end
        PhPath: begin
          run_path = 1'b1;
        end
        PhQuery: begin
          if (c == ChHash) begin
            len_d[C_QUERY]  = span(start_q[C_QUERY], pos);
            pres_d[C_FRAG]  = 1'b1;
            start_d[C_FRAG] = sat_inc(pos);
            len_d[C_FRAG]   = '0;
            phase_d         = PhFrag;
          end
        end
        default: begin
        end
      endcase
      pos_d = sat_inc(pos);
    end else if (accept_i) begin
      if (pos_q > PosCap) begin
        pos = PosCap;
      end
      case (phase_q)
        PhScheme, PhAfter, PhSlash, PhPath: begin
          run_end_path = 1'b1;
        end
        PhAuth: begin
          run_end_auth = 1'b1;
          run_end_path = 1'b1;
        end
        PhQuery: begin
          len_d[C_QUERY] = span(start_q[C_QUERY], pos);
        end
        PhFrag: begin
          len_d[C_FRAG] = span(start_q[C_FRAG], pos);
        end
        default: begin
        end
      endcase
    end

    if (run_end_auth) begin
      match5 = pres_d[C_SCHEME] && (len_d[C_SCHEME] >= PosW'(5)) && (prefix_d == HttpsWord);
      match4 = pres_d[C_SCHEME] && (len_d[C_SCHEME] >= PosW'(4)) &&
               (prefix_d[31:0] == HttpsWord[31:0]);
      len_d[C_AUTH] = span(start_d[C_AUTH], pos);
      if (pres_d[C_HOST]) begin
        if (colon_seen_d) begin
          len_d[C_HOST] = span(start_d[C_HOST], colon_pos_d);
        end else begin
          len_d[C_HOST] = span(start_d[C_HOST], pos);
          acc_d = match5 ? PortHttps : (match4 ? PortHttp : '0);
        end
      end else begin
        acc_d = '0;
      end
      digits_d        = 1'b0;
      colon_seen_d    = 1'b0;
      start_d[C_PATH] = pos;
      phase_d         = PhPath;
    end

    if (run_path) begin
      if (c == ChSlash) begin
        pres_d[C_NAME]  = 1'b1;
        start_d[C_NAME] = sat_inc(pos);
        len_d[C_NAME]   = '0;
      end else if (c == ChQuest) begin
        run_end_path     = 1'b1;
        pres_d[C_QUERY]  = 1'b1;
        start_d[C_QUERY] = sat_inc(pos);
        len_d[C_QUERY]   = '0;
        phase_d          = PhQuery;
      end else if (c == ChHash) begin
        run_end_path    = 1'b1;
        pres_d[C_FRAG]  = 1'b1;
        start_d[C_FRAG] = sat_inc(pos);
        len_d[C_FRAG]   = '0;
        phase_d         = PhFrag;
      end
    end

    if (run_end_path) begin
      len_d[C_PATH] = span(start_d[C_PATH], pos);
      if (pres_d[C_NAME]) begin
        len_d[C_NAME] = span(start_d[C_NAME], pos);
      end
    end

    if (accept_i && req_i.end_of_url) begin
      pres_d[C_PATH] = 1'b1;
      snap_push_o    = 1'b1;
      snap_o.pres    = pres_d;
      snap_o.start   = start_d;
      snap_o.len     = len_d;
      snap_o.port    = acc_d;
      snap_o.ovf     = ovf_d;
      phase_d        = PhScheme;
      pos_d          = '0;
      prefix_d       = '0;
      start_d        = '0;
      len_d          = '0;
      pres_d         = '0;
      colon_pos_d    = '0;
      colon_seen_d   = 1'b0;
      acc_d          = '0;
      digits_d       = 1'b0;
      ovf_d          = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhScheme;
      pos_q        <= '0;
      prefix_q     <= '0;
      start_q      <= '0;
      len_q        <= '0;
      pres_q       <= '0;
      colon_pos_q  <= '0;
      colon_seen_q <= 1'b0;
      acc_q        <= '0;
      digits_q     <= 1'b0;
      ovf_q        <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      prefix_q     <= prefix_d;
      start_q      <= start_d;
      len_q        <= len_d;
      pres_q       <= pres_d;
      colon_pos_q  <= colon_pos_d;
      colon_seen_q <= colon_seen_d;
      acc_q        <= acc_d;
      digits_q     <= digits_d;
      ovf_q        <= ovf_d;
    end
  end

endmodule

// ===== hdl/ucs_snap_fifo.sv =====
// ----------------------------------------------------------------------------
// ucs_snap_fifo
// Short queue of finished URL snapshots between the scanner and the emitter.
// ----------------------------------------------------------------------------
module ucs_snap_fifo import ucs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ucs_snap_t push_data_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      head_valid_o,
  output ucs_snap_t head_o
);

  localparam int unsigned PtrW = (SnapDepth > 1) ? $clog2(SnapDepth) : 1;
  localparam int unsigned CntW = $clog2(SnapDepth + 1);

  ucs_snap_t           mem_q [SnapDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(SnapDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o       = (cnt_q == CntW'(SnapDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== hdl/ucs_emit.sv =====
// ----------------------------------------------------------------------------
// ucs_emit
// Back end: walks the nine components of the head snapshot and presents one
// record per cycle while the receiver is ready, through an output register.
// ----------------------------------------------------------------------------
module ucs_emit import ucs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  ucs_snap_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ucs_out_t  out_rec_o
);

  logic [CompW-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  ucs_out_t         out_rec_q, out_rec_d;
  logic             load;
  logic             is_last;

  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = (idx_q == C_FRAG);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_rec_d   = out_rec_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d           = 1'b1;
      out_rec_d.component   = idx_q;
      out_rec_d.present     = head_i.pres[idx_q];
      out_rec_d.start_res   = head_i.pres[idx_q] ? head_i.start[idx_q] : '0;
      out_rec_d.length      = head_i.pres[idx_q] ? head_i.len[idx_q] : '0;
      out_rec_d.port        = head_i.port;
      out_rec_d.too_long    = head_i.ovf;
      out_rec_d.last_record = is_last;
      idx_d                 = is_last ? '0 : idx_q + CompW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rec_q <= out_rec_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_rec_q;

endmodule

// ===== hdl/url_component_splitter.sv =====
// ----------------------------------------------------------------------------
// url_component_splitter
// Splits a URL, streamed one byte per request, into its components.
// ----------------------------------------------------------------------------
// Usage:
// The in_i channel carries one URL byte per request; a request with
// end_of_url set closes the URL. The out_o channel then carries nine records,
// scheme through fragment in order, the ninth with last_record set.
// Byte requests are taken one per cycle while in_i.ready is high; parsing
// state is updated in the cycle the byte is taken.
// The terminator freezes the result into a two-entry snapshot queue and the
// parser is clear for the next URL at once. The head snapshot is read from
// the queue into the output register one record per cycle while out_o.ready
// is high, nine records per URL.
// in_i.ready drops only while both queue entries wait for the output side;
// a stalled receiver holds the current record in the output register.
// Reset clears the parser, the queue and the output valid flag, not the record.
// ----------------------------------------------------------------------------
module url_component_splitter import ucs_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ucs_stream_if.sink   in_i,
  ucs_stream_if.source out_o
);

  logic      accept;
  logic      snap_push;
  ucs_snap_t snap;
  logic      fifo_full;
  logic      head_valid;
  ucs_snap_t head;
  logic      pop;

  assign in_i.ready = !fifo_full;
  assign accept     = in_i.valid && !fifo_full;

  ucs_scan #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (in_i.payload),
    .snap_push_o (snap_push),
    .snap_o      (snap)
  );

  ucs_snap_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (snap_push),
    .push_data_i  (snap),
    .pop_i        (pop),
    .full_o       (fifo_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  ucs_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_rec_o    (out_o.payload)
  );

endmodule

// ===== hdl/ucs_checker.sv =====
// ----------------------------------------------------------------------------
// ucs_checker
// Port-level checks on the record stream of the URL component splitter.
// ----------------------------------------------------------------------------
module ucs_checker import ucs_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input ucs_out_t out_rec_i
);

  default disable iff (!rst_ni);

  a_hold_valid : assert property (@(posedge clk_i)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Record request dropped while stalled.");

  a_last_is_fragment : assert property (@(posedge clk_i)
    out_valid_i |-> (out_rec_i.last_record == (out_rec_i.component == C_FRAG)))
    else $error("Last record flag does not match the fragment record.");

  a_absent_zero : assert property (@(posedge clk_i)
    out_valid_i && !out_rec_i.present |->
      out_rec_i.start_res == '0 && out_rec_i.length == '0)
    else $error("Absent component carries an offset or length.");

  a_path_present : assert property (@(posedge clk_i)
    out_valid_i && out_rec_i.component == C_PATH |-> out_rec_i.present)
    else $error("Path record is not marked present.");

  a_order : assert property (@(posedge clk_i)
    out_valid_i && out_ready_i && !out_rec_i.last_record ##1 out_valid_i |->
      out_rec_i.component == $past(out_rec_i.component) + CompW'(1))
    else $error("Records are out of component order.");

endmodule

bind url_component_splitter ucs_checker u_ucs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_rec_i   (out_o.payload)
);
